// ===== hdl/wpbs_pkg.sv =====
// Package for the wheel power budget scaler.
// Widths, the Q1.15 unity constant and the pipeline stage word shared by all files.
`timescale 1ns / 1ps
package wpbs_pkg;

  localparam int unsigned Wheels   = 4;
  localparam int unsigned PowerW   = 24;  // signed wheel power, 1/256 W
  localparam int unsigned BudgetW  = 22;  // configured budget, 1/256 W
  localparam int unsigned ConsW    = 25;  // sum of positive powers
  localparam int unsigned AvailW   = 26;  // budget plus regenerated power
  localparam int unsigned FactorW  = 16;  // Q1.15 factor
  localparam int unsigned QuoW     = 15;  // quotient bits, below unity
  localparam int unsigned DivSteps = QuoW;

  localparam logic [FactorW-1:0] FactorOne = 16'h8000;

  // One word of the divider pipeline
  typedef struct packed {
    logic [AvailW-1:0] rem;   // partial remainder, starts at available power
    logic [ConsW-1:0]  dvs;   // divisor, the consumption
    logic [QuoW-1:0]   quo;   // quotient bits developed so far
    logic [Wheels-1:0] pos;   // wheels drawing positive power
    logic              one;   // consumption within budget, factor is unity
  } wpbs_stage_t;

endpackage

// ===== hdl/wpbs_if.sv =====
// Channel interfaces of the wheel power budget scaler: config, wheel powers, factors.
// Depends on wpbs_pkg for the field widths.
`timescale 1ns / 1ps
interface wpbs_cfg_if import wpbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BudgetW-1:0] power_budget;

  modport source (output valid, output power_budget, input ready);
  modport sink   (input valid, input power_budget, output ready);
endinterface

interface wpbs_in_if import wpbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PowerW-1:0] power_wheel_0;
  logic [PowerW-1:0] power_wheel_1;
  logic [PowerW-1:0] power_wheel_2;
  logic [PowerW-1:0] power_wheel_3;

  modport source (output valid, output power_wheel_0, output power_wheel_1,
                  output power_wheel_2, output power_wheel_3, input ready);
  modport sink   (input valid, input power_wheel_0, input power_wheel_1,
                  input power_wheel_2, input power_wheel_3, output ready);
endinterface

interface wpbs_out_if import wpbs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FactorW-1:0] shared_factor;
  logic [FactorW-1:0] factor_wheel_0;
  logic [FactorW-1:0] factor_wheel_1;
  logic [FactorW-1:0] factor_wheel_2;
  logic [FactorW-1:0] factor_wheel_3;

  modport source (output valid, output shared_factor, output factor_wheel_0,
                  output factor_wheel_1, output factor_wheel_2, output factor_wheel_3,
                  input ready);
  modport sink   (input valid, input shared_factor, input factor_wheel_0,
                  input factor_wheel_1, input factor_wheel_2, input factor_wheel_3,
                  output ready);
endinterface

// ===== hdl/wheel_power_budget_scaler.sv =====
// Wheel power budget scaler: scales four wheel power demands to a chassis budget.
// Channels:
//   cfg_i  - writes power_budget (1/256 W); always ready, takes effect at once.
//   pwr_i  - one word of four signed wheel powers (1/256 W), valid/ready.
//   fac_o  - one word of Q1.15 factors per input word, valid/ready.
// Positive powers add up to consumption; zero or negative powers add their
// magnitude to the budget. If consumption exceeds that, the shared factor is
// available * 32768 / consumption, truncated; otherwise 32768. Wheels with
// positive power get the shared factor, the rest get 32768.
// Pipeline: two summing and compare stages, then 15 divider stages,
// one quotient bit each.
// Throughput: one word per cycle while fac_o accepts words.
// Reset clears the budget to 0 and all stage valid bits; no word is in flight.
// A stalled receiver holds the output word; stages behind it keep filling
// bubbles, and pwr_i.ready drops only when every stage holds a word.
// Depends on wpbs_pkg, wpbs_if, wpbs_front and wpbs_div_step.
`timescale 1ns / 1ps
module wheel_power_budget_scaler import wpbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpbs_cfg_if.sink  cfg_i,
  wpbs_in_if.sink   pwr_i,
  wpbs_out_if.source fac_o
);

  logic [BudgetW-1:0]            budget_q;
  logic [Wheels-1:0][PowerW-1:0] power;
  logic                          vld [DivSteps+1];
  logic                          rdy [DivSteps+1];
  wpbs_stage_t                   stg [DivSteps+1];
  wpbs_stage_t                   last;
  logic [FactorW-1:0]            shared;

  // Budget register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (cfg_i.valid) begin
      budget_q <= cfg_i.power_budget;
    end
  end

  assign power[0] = pwr_i.power_wheel_0;
  assign power[1] = pwr_i.power_wheel_1;
  assign power[2] = pwr_i.power_wheel_2;
  assign power[3] = pwr_i.power_wheel_3;

  wpbs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .budget_i (budget_q),
    .valid_i  (pwr_i.valid),
    .ready_o  (pwr_i.ready),
    .power_i  (power),
    .valid_o  (vld[0]),
    .ready_i  (rdy[0]),
    .stage_o  (stg[0])
  );

  // Divider chain
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    wpbs_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .ready_o (rdy[g]),
      .stage_i (stg[g]),
      .valid_o (vld[g+1]),
      .ready_i (rdy[g+1]),
      .stage_o (stg[g+1])
    );
  end

  // Output word from the last stage
  assign last            = stg[DivSteps];
  assign rdy[DivSteps]   = fac_o.ready;
  assign fac_o.valid     = vld[DivSteps];
  assign shared          = last.one ? FactorOne : FactorW'(last.quo);
  assign fac_o.shared_factor  = shared;
  assign fac_o.factor_wheel_0 = last.pos[0] ? shared : FactorOne;
  assign fac_o.factor_wheel_1 = last.pos[1] ? shared : FactorOne;
  assign fac_o.factor_wheel_2 = last.pos[2] ? shared : FactorOne;
  assign fac_o.factor_wheel_3 = last.pos[3] ? shared : FactorOne;

endmodule

// ===== hdl/wpbs_front.sv =====
// Front end: sums consumption and available power, then compares them.
// Two register stages with their own valid bits; depends on wpbs_pkg.
`timescale 1ns / 1ps
module wpbs_front import wpbs_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [BudgetW-1:0]            budget_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [Wheels-1:0][PowerW-1:0] power_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output wpbs_stage_t                   stage_o
);

  logic              a_valid_q;
  logic [ConsW-1:0]  a_cons_q, a_cons_d;
  logic [AvailW-1:0] a_avail_q, a_avail_d;
  logic [Wheels-1:0] a_pos_q, a_pos_d;
  logic              b_valid_q;
  wpbs_stage_t       b_stage_q, b_stage_d;
  logic              a_adv, b_adv;

  // Stage A: split powers into consumption and regenerated magnitude
  always_comb begin
    logic [PowerW-1:0] mag;
    a_cons_d  = '0;
    a_avail_d = AvailW'(budget_i);
    for (int k = 0; k < Wheels; k++) begin
      mag        = '0 - power_i[k];
      a_pos_d[k] = !power_i[k][PowerW-1] && (power_i[k] != '0);
      if (a_pos_d[k]) begin
        a_cons_d = a_cons_d + ConsW'(power_i[k]);
      end else begin
        a_avail_d = a_avail_d + AvailW'(mag);
      end
    end
  end

  // Stage B: decide whether a reduction is needed, seed the divider
  always_comb begin
    b_stage_d.rem = a_avail_q;
    b_stage_d.dvs = a_cons_q;
    b_stage_d.quo = '0;
    b_stage_d.pos = a_pos_q;
    b_stage_d.one = (AvailW'(a_cons_q) <= a_avail_q);
  end

  // Advance a stage when it is empty or its successor moves
  assign b_adv   = !b_valid_q || ready_i;
  assign a_adv   = !a_valid_q || b_adv;
  assign ready_o = a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) a_valid_q <= valid_i;
      if (b_adv) b_valid_q <= a_valid_q;
    end
  end

  // Payload: load only on a real word
  always_ff @(posedge clk_i) begin
    if (a_adv && valid_i) begin
      a_cons_q  <= a_cons_d;
      a_avail_q <= a_avail_d;
      a_pos_q   <= a_pos_d;
    end
    if (b_adv && a_valid_q) begin
      b_stage_q <= b_stage_d;
    end
  end

  assign valid_o = b_valid_q;
  assign stage_o = b_stage_q;

endmodule

// ===== hdl/wpbs_div_step.sv =====
// One restoring division step: develops one quotient bit per register stage.
// Depends on wpbs_pkg for the stage word.
`timescale 1ns / 1ps
module wpbs_div_step import wpbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  wpbs_stage_t stage_i,
  output logic        valid_o,
  input  logic        ready_i,
  output wpbs_stage_t stage_o
);

  logic        valid_q;
  wpbs_stage_t stage_q, stage_d;
  logic        adv;

  // Shift remainder, subtract divisor where it fits
  always_comb begin
    logic [AvailW:0] r2;
    logic [AvailW:0] dv;
    logic            ge;
    r2 = {stage_i.rem, 1'b0};
    dv = (AvailW + 1)'(stage_i.dvs);
    ge = (r2 >= dv);
    stage_d     = stage_i;
    stage_d.rem = ge ? AvailW'(r2 - dv) : AvailW'(r2);
    stage_d.quo = {stage_i.quo[QuoW-2:0], ge};
  end

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

// ===== hdl/wpbs_checker.sv =====
// Port-level checker for the wheel power budget scaler, bound to the top level.
// Depends on wpbs_pkg and the top level's interface ports.
`timescale 1ns / 1ps
module wpbs_checker import wpbs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [FactorW-1:0] shared_i,
  input logic [FactorW-1:0] fw0_i,
  input logic [FactorW-1:0] fw1_i,
  input logic [FactorW-1:0] fw2_i,
  input logic [FactorW-1:0] fw3_i
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(shared_i) &&
    $stable(fw0_i) && $stable(fw1_i) && $stable(fw2_i) && $stable(fw3_i))
    else $error("output word changed while stalled");

  // Shared factor never exceeds unity
  a_shared_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> shared_i <= FactorOne)
    else $error("shared factor above unity");

  // Each wheel gets either the shared factor or unity
  a_wheel_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (fw0_i == shared_i || fw0_i == FactorOne) &&
                    (fw1_i == shared_i || fw1_i == FactorOne) &&
                    (fw2_i == shared_i || fw2_i == FactorOne) &&
                    (fw3_i == shared_i || fw3_i == FactorOne))
    else $error("wheel factor is neither shared nor unity");

  // Input backpressure only comes from a full pipeline held at the output
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output stall");

endmodule

bind wheel_power_budget_scaler wpbs_checker u_wpbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pwr_i.ready),
  .out_valid_i (fac_o.valid),
  .out_ready_i (fac_o.ready),
  .shared_i    (fac_o.shared_factor),
  .fw0_i       (fac_o.factor_wheel_0),
  .fw1_i       (fac_o.factor_wheel_1),
  .fw2_i       (fac_o.factor_wheel_2),
  .fw3_i       (fac_o.factor_wheel_3)
);

// ===== tb/tb_wheel_power_budget_scaler.sv =====
// Testbench for the wheel power budget scaler: drives wheel power words and budget writes,
// predicts every factor word in its own model and checks the results in order.
// Depends on wpbs_pkg, the wpbs_if channel interfaces and the wheel_power_budget_scaler RTL.
`timescale 1ns / 1ps
module tb_wheel_power_budget_scaler;
  import wpbs_pkg::*;

  localparam logic [PowerW-1:0]  PowerMax   = 24'h7FFFFF;
  localparam logic [PowerW-1:0]  PowerMin   = 24'h800000;
  localparam logic [BudgetW-1:0] BudgetMax  = '1;
  localparam int unsigned        TailCycles = 24;      // pipeline is 17 deep
  localparam int unsigned        CycleLimit = 600000;  // several times the slowest run
  localparam int unsigned        HoldCycles = 400;
  localparam int unsigned        Phases     = 9;
  localparam int unsigned        PhaseWords = 120;

  typedef struct packed {
    logic [FactorW-1:0]             shared;
    logic [Wheels-1:0][FactorW-1:0] wheel;
  } factor_set_t;

  logic clk;
  logic rst_n;

  wpbs_cfg_if cfg_if ();
  wpbs_in_if  pwr_if ();
  wpbs_out_if fac_if ();

  wheel_power_budget_scaler u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .pwr_i  (pwr_if),
    .fac_o  (fac_if)
  );

  // Model state and bookkeeping
  logic [BudgetW-1:0] budget_q;
  factor_set_t        factor_queue[$];
  int unsigned        errors;
  int unsigned        words_sent;
  int unsigned        words_checked;
  int unsigned        budget_writes;
  int unsigned        cycle_cnt;
  bit                 src_gaps;
  bit                 sink_stalls;
  int unsigned        sink_hold_req;
  int unsigned        sink_hold_len;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CycleLimit) begin
        $display("FAIL wheel_power_budget_scaler");
        $finish;
      end
    end
  end

  // Gap length: mostly short, sometimes medium, rarely long
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Expected factors for one word of wheel powers under a given budget
  function automatic factor_set_t predict_factors(input logic [BudgetW-1:0] budget,
                                                  input logic [Wheels-1:0][PowerW-1:0] pw);
    logic [AvailW-1:0]       avail;
    logic [ConsW-1:0]        load;
    logic [AvailW+QuoW-1:0]  quo;
    logic [FactorW-1:0]      shared;
    factor_set_t             res;
    avail  = AvailW'(budget);
    load   = '0;
    shared = FactorOne;
    // Split positive draw from regenerated and idle power
    for (int i = 0; i < Wheels; i++) begin
      if ($signed(pw[i]) > 0) load += ConsW'(pw[i]);
      else avail += AvailW'(-$signed({pw[i][PowerW-1], pw[i]}));
    end
    if (load > avail) begin
      quo    = {avail, QuoW'(0)} / (AvailW+QuoW)'(load);
      shared = quo[FactorW-1:0];
    end
    res.shared = shared;
    for (int i = 0; i < Wheels; i++)
      res.wheel[i] = ($signed(pw[i]) > 0) ? shared : FactorOne;
    return res;
  endfunction

  // Wheel power with weight on extremes, zero and values up to half the budget
  function automatic logic [PowerW-1:0] rand_power();
    int unsigned       pick;
    logic [PowerW-1:0] v;
    pick = $urandom_range(0, 11);
    case (pick)
      0: v = '0;
      1: v = PowerMax;
      2: v = PowerMin;
      3, 4, 5: v = PowerW'($urandom);
      6, 7: v = PowerW'($urandom_range(1, 32'h000FFFFF));
      8: v = PowerW'(-int'($urandom_range(1, 32'h000FFFFF)));
      9: v = PowerW'($urandom_range(0, int'(budget_q) / 2 + 1));
      10: v = PowerW'(-int'($urandom_range(1, 255)));
      default: v = PowerW'($urandom_range(1, 255));
    endcase
    return v;
  endfunction

  // Offer one word; return at the edge that accepts it, valid still high
  task automatic send_power(input logic [PowerW-1:0] w0, input logic [PowerW-1:0] w1,
                            input logic [PowerW-1:0] w2, input logic [PowerW-1:0] w3);
    int unsigned                    gap;
    logic [Wheels-1:0][PowerW-1:0] pw;
    gap = (src_gaps && $urandom_range(0, 99) < 30) ? rand_gap() : 0;
    if (gap > 0) begin
      pwr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pwr_if.valid         <= 1'b1;
    pwr_if.power_wheel_0 <= w0;
    pwr_if.power_wheel_1 <= w1;
    pwr_if.power_wheel_2 <= w2;
    pwr_if.power_wheel_3 <= w3;
    @(posedge clk);
    while (!pwr_if.ready) @(posedge clk);
    pw = {w3, w2, w1, w0};
    factor_queue = {factor_queue, predict_factors(budget_q, pw)};
    words_sent++;
  endtask

  // Drop valid and hold until every expected factor word has arrived
  task automatic wait_drained();
    pwr_if.valid <= 1'b0;
    while (factor_queue.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // Write the budget register with the pipeline empty
  task automatic write_budget(input logic [BudgetW-1:0] value);
    wait_drained();
    cfg_if.valid        <= 1'b1;
    cfg_if.power_budget <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    budget_q = value;
    budget_writes++;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req != hold_seen) begin
        hold_seen  = sink_hold_req;
        stall_left = sink_hold_len;
      end
      if (!rst_n) begin
        fac_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        fac_if.ready <= 1'b0;
        stall_left--;
      end else begin
        fac_if.ready <= 1'b1;
        if (sink_stalls && $urandom_range(0, 99) < 20) stall_left = rand_gap();
      end
    end
  end

  // Compare each accepted factor word with the oldest prediction
  always @(posedge clk) begin : check_factors
    factor_set_t want;
    if (rst_n && fac_if.valid && fac_if.ready) begin
      if (factor_queue.size() == 0) begin
        $display("%0t: unexpected factor word shared=%0d", $time, fac_if.shared_factor);
        errors++;
      end else begin
        want = factor_queue.pop_front();
        words_checked++;
        if (fac_if.shared_factor !== want.shared) begin
          $display("%0t: shared_factor expected %0d got %0d", $time, want.shared,
                   fac_if.shared_factor);
          errors++;
        end
        if (fac_if.factor_wheel_0 !== want.wheel[0]) begin
          $display("%0t: factor_wheel_0 expected %0d got %0d", $time, want.wheel[0],
                   fac_if.factor_wheel_0);
          errors++;
        end
        if (fac_if.factor_wheel_1 !== want.wheel[1]) begin
          $display("%0t: factor_wheel_1 expected %0d got %0d", $time, want.wheel[1],
                   fac_if.factor_wheel_1);
          errors++;
        end
        if (fac_if.factor_wheel_2 !== want.wheel[2]) begin
          $display("%0t: factor_wheel_2 expected %0d got %0d", $time, want.wheel[2],
                   fac_if.factor_wheel_2);
          errors++;
        end
        if (fac_if.factor_wheel_3 !== want.wheel[3]) begin
          $display("%0t: factor_wheel_3 expected %0d got %0d", $time, want.wheel[3],
                   fac_if.factor_wheel_3);
          errors++;
        end
      end
    end
  end

  // Budget left at its reset value of zero: a positive draw with no regenerated power collapses the factor
  task automatic test_reset_budget();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    send_power('0, '0, '0, '0);
    send_power(24'd1, '0, '0, '0);
    send_power(PowerMax, PowerMax, PowerMax, PowerMax);
    send_power(PowerMin, PowerMin, PowerMin, PowerMin);
    send_power(PowerMax, PowerMin, '0, '0);
    // regenerated power exactly equal to the draw, then one short of it
    send_power(PowerMax, PowerMin + 24'd1, '0, '0);
    send_power(PowerMax, PowerMin + 24'd2, '0, '0);
    send_power(24'd100, -24'sd50, '0, '0);
    send_power(-24'sd1, -24'sd1, -24'sd1, 24'd3);
  endtask

  // Largest and smallest nonzero budgets against boundary draws
  task automatic test_budget_extremes();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    write_budget(BudgetMax);
    send_power('0, '0, '0, '0);
    send_power(24'd4194303, '0, '0, '0);
    send_power(24'd4194304, '0, '0, '0);
    send_power(PowerMax, PowerMax, PowerMax, PowerMax);
    send_power(PowerMax, PowerMin, PowerMax, PowerMin);
    send_power(24'd1, PowerMax, -24'sd1, '0);
    send_power(PowerMin, PowerMin, PowerMin, PowerMax);
    write_budget(22'd1);
    send_power(24'd2, '0, '0, '0);
    send_power(24'd3, '0, '0, -24'sd1);
    send_power(PowerMax, 24'd1, 24'd1, 24'd1);
    send_power('0, 24'd1, '0, '0);
  endtask

  // Long receiver hold-off while words keep coming, so the input stalls
  task automatic test_output_backpressure();
    write_budget(22'd1000000);
    src_gaps      = 1'b0;
    sink_stalls   = 1'b0;
    sink_hold_len = HoldCycles;
    sink_hold_req++;
    for (int i = 0; i < 50; i++)
      send_power(rand_power(), rand_power(), rand_power(), rand_power());
    wait_drained();
  endtask

  // Random words over a series of budgets and idling patterns
  task automatic test_random_budgets();
    logic [BudgetW-1:0] bud;
    for (int ph = 0; ph < Phases; ph++) begin
      if (ph == 0) bud = '0;
      else if (ph == 1) bud = BudgetMax;
      else if (ph % 2 == 0) bud = BudgetW'($urandom);
      else bud = BudgetW'($urandom_range(1, 65535));
      write_budget(bud);
      src_gaps    = (ph % 3 != 0);
      sink_stalls = (ph % 4 != 1);
      for (int i = 0; i < PhaseWords; i++) begin
        send_power(rand_power(), rand_power(), rand_power(), rand_power());
        // occasionally pause until the pipeline runs dry
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
    end
  endtask

  // Reset, run the tests in turn, report
  initial begin
    rst_n                = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.power_budget  = '0;
    pwr_if.valid         = 1'b0;
    pwr_if.power_wheel_0 = '0;
    pwr_if.power_wheel_1 = '0;
    pwr_if.power_wheel_2 = '0;
    pwr_if.power_wheel_3 = '0;
    fac_if.ready         = 1'b0;
    budget_q             = '0;
    errors               = 0;
    words_sent           = 0;
    words_checked        = 0;
    budget_writes        = 0;
    src_gaps             = 1'b0;
    sink_stalls          = 1'b0;
    sink_hold_req        = 0;
    sink_hold_len        = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_budget();
    test_budget_extremes();
    test_output_backpressure();
    test_random_budgets();
    wait_drained();
    $display("Sent %0d wheel power words, checked %0d factor words, %0d budget writes",
             words_sent, words_checked, budget_writes);
    $display("Covered zero and full budgets, boundary draws, stalls and a long hold-off");
    if (errors == 0) begin
      $display("PASS wheel_power_budget_scaler");
    end else begin
      $display("FAIL wheel_power_budget_scaler");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wpbs_pkg.sv
hdl/wpbs_if.sv
hdl/wpbs_front.sv
hdl/wpbs_div_step.sv
hdl/wheel_power_budget_scaler.sv
hdl/wpbs_checker.sv
tb/tb_wheel_power_budget_scaler.sv
